// ===== design/assert_macros.svh =====
// Assertion macros shared by the disk ID mask table RTL.
// No dependencies; included by every module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define ASSERT_SYNC(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/dimt_pkg.sv =====
// Shared types and constants of the disk ID mask table.
// No dependencies; imported by dimt_ctrl, dimt_dp and disk_id_mask_table.
package dimt_pkg;

    localparam int DISK_SLOTS = 16;
    localparam int SLOT_W     = (DISK_SLOTS > 1) ? $clog2(DISK_SLOTS) : 1;
    localparam int CNT_W      = 8;
    localparam int SIG_W      = 32;
    localparam int GUID_W     = 64;
    localparam int KEY_W      = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SIG_W-1:0] GOLDEN_STEP = 32'h9E37_79B9;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_GET     = 2'd1,
        REQ_RESOLVE = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HI = 2'd0,
        CFG_KEY_LO = 2'd1,
        CFG_ARMED  = 2'd2
    } t_cfg_idx;

    // What the result beat carries.
    typedef enum logic [1:0] {
        K_FAIL = 2'd0,
        K_OK   = 2'd1,
        K_GET  = 2'd2,
        K_RES  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [SIG_W-1:0]  real_sig;
        logic [SIG_W-1:0]  msig;
        logic [GUID_W-1:0] mghi;
        logic [GUID_W-1:0] mglo;
    } t_slot;

    typedef struct packed {
        logic  load;
        logic  add;
        logic  clr;
        logic  rd;
        logic  scan_init;
        logic  scan;
        logic  post;
        t_kind kind;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic armed;
        logic idx_ok;
        logic active;
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/disk_id_mask_table.sv =====
// Top level of the disk ID mask table.
// Depends on dimt_pkg, dimt_ctrl and dimt_dp.
//
// Disk ID mask table: keeps up to DISK_SLOTS disk slots whose MBR signatures
// and GPT GUIDs are stored behind XOR masks derived from a 128-bit key and the
// slot number. Requests come in as one beat each: add, get, resolve, clear;
// every request answers with exactly one result beat, which carries the slot
// count after the request. Load the key through the write port, then set the
// armed register; while disarmed every request fails and changes nothing.
// One request is worked on at a time. Add, clear, a get of an inactive slot
// and every request refused for being disarmed or for a bad index go from
// execution straight to posting their result; a get of an active slot first
// reads its entry. Resolve reads the slot memory one entry per cycle through
// its single read port and compares each entry in the cycle after its read,
// stopping at the first match or once every counted slot is compared. A
// result that finds the output register still full holds in the sequencer
// until the register has room. The next request is taken as soon as the
// previous result is posted, even while that result still waits for
// o_out_valid/i_out_ready. Reset (synchronous, active low) clears the key,
// the armed bit, all slot active bits and the count at once; there is no
// clearing pass. Write configuration only while no request is in flight.
module disk_id_mask_table import dimt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [CNT_W-1:0]     i_disk_index,
    input  logic [SIG_W-1:0]     i_mbr_sig,
    input  logic [GUID_W-1:0]    i_guid_hi,
    input  logic [GUID_W-1:0]    i_guid_lo,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_status,
    output logic [CNT_W-1:0]     o_found_index,
    output logic [SIG_W-1:0]     o_sig_out,
    output logic [GUID_W-1:0]    o_masked_guid_hi,
    output logic [GUID_W-1:0]    o_masked_guid_lo,
    output logic [CNT_W-1:0]     o_slot_count
);

    // Commands flow down to the datapath, status flows back up.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: accept a beat, dispatch by request type, run the scan,
    // hold the result until the output register has room.
    dimt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: key registers, masking, slot memory, scan compare and the
    // result register that drives the output channel.
    dimt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_disk_index     (i_disk_index),
        .i_mbr_sig        (i_mbr_sig),
        .i_guid_hi        (i_guid_hi),
        .i_guid_lo        (i_guid_lo),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_found_index    (o_found_index),
        .o_sig_out        (o_sig_out),
        .o_masked_guid_hi (o_masked_guid_hi),
        .o_masked_guid_lo (o_masked_guid_lo),
        .o_slot_count     (o_slot_count)
    );

endmodule

// ===== design/dimt_ctrl.sv =====
// Request sequencer of the disk ID mask table.
// Depends on dimt_pkg and assert_macros.svh; drives the datapath dimt_dp.
`include "assert_macros.svh"

module dimt_ctrl import dimt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_GETRD = 5'b00100,
        S_SCAN  = 5'b01000,
        S_POST  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind,  n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_FAIL;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.armed ||
                    ((i_stat.req == REQ_ADD || i_stat.req == REQ_GET) && !i_stat.idx_ok)) begin
                    n_kind  = K_FAIL;
                    n_state = S_POST;
                end else begin
                    unique case (i_stat.req)
                        REQ_ADD: begin
                            o_cmd.add = 1'b1;
                            n_kind    = K_OK;
                            n_state   = S_POST;
                        end
                        REQ_GET: begin
                            if (i_stat.active) begin
                                o_cmd.rd = 1'b1;
                                n_state  = S_GETRD;
                            end else begin
                                n_kind  = K_FAIL;
                                n_state = S_POST;
                            end
                        end
                        REQ_RESOLVE: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                        REQ_CLEAR: begin
                            o_cmd.clr = 1'b1;
                            n_kind    = K_OK;
                            n_state   = S_POST;
                        end
                        default: n_state = S_POST;
                    endcase
                end
            end
            S_GETRD: begin
                n_kind  = K_GET;
                n_state = S_POST;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit) begin
                    n_kind  = K_RES;
                    n_state = S_POST;
                end else if (i_stat.scan_done) begin
                    n_kind  = K_FAIL;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (i_stat.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_NEVER(a_post_needs_room, i_clk, i_rst_n, o_cmd.post && !i_stat.out_free, "result posted into a full output register")
    `ASSERT_SYNC(a_accept_to_exec, i_clk, i_rst_n, (r_state == S_IDLE && i_in_valid) |=> (r_state == S_EXEC), "accepted request did not enter execution")
    `ASSERT_SYNC(a_add_guarded, i_clk, i_rst_n, o_cmd.add |-> (i_stat.armed && i_stat.idx_ok), "table written while unarmed or with a bad index")

endmodule

// ===== design/dimt_dp.sv =====
// Datapath of the disk ID mask table: key registers, slot memory, scan pointer,
// result register. Depends on dimt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dimt_dp import dimt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data,
    input  logic [1:0]           i_req_type,
    input  logic [CNT_W-1:0]     i_disk_index,
    input  logic [SIG_W-1:0]     i_mbr_sig,
    input  logic [GUID_W-1:0]    i_guid_hi,
    input  logic [GUID_W-1:0]    i_guid_lo,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_status,
    output logic [CNT_W-1:0]     o_found_index,
    output logic [SIG_W-1:0]     o_sig_out,
    output logic [GUID_W-1:0]    o_masked_guid_hi,
    output logic [GUID_W-1:0]    o_masked_guid_lo,
    output logic [CNT_W-1:0]     o_slot_count
);

    // Configuration
    logic [KEY_W-1:0] r_key_hi, r_key_lo;
    logic             r_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_armed  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HI: r_key_hi <= i_cfg_data;
                CFG_KEY_LO: r_key_lo <= i_cfg_data;
                CFG_ARMED:  r_armed  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Request latch
    t_req              r_req;
    logic [CNT_W-1:0]  r_idx;
    logic [SIG_W-1:0]  r_sig;
    logic [GUID_W-1:0] r_ghi, r_glo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= t_req'(i_req_type);
            r_idx <= i_disk_index;
            r_sig <= i_mbr_sig;
            r_ghi <= i_guid_hi;
            r_glo <= i_guid_lo;
        end
    end

    logic [SLOT_W-1:0] w_slot;
    assign w_slot = r_idx[SLOT_W-1:0];

    // Masks for the latched slot
    logic [SIG_W-1:0]  w_key_fold, w_sig_mask;
    logic [GUID_W-1:0] w_guid_pat;
    t_slot             w_wr_data;

    assign w_key_fold = r_key_hi[63:32] ^ r_key_hi[31:0] ^ r_key_lo[63:32] ^ r_key_lo[31:0];
    assign w_sig_mask = w_key_fold ^ SIG_W'(SIG_W'(r_idx) * GOLDEN_STEP);
    assign w_guid_pat = {r_idx, 24'h0, r_idx, 24'h0};

    assign w_wr_data.real_sig = r_sig;
    assign w_wr_data.msig     = r_sig ^ w_sig_mask;
    assign w_wr_data.mghi     = r_ghi ^ r_key_hi ^ w_guid_pat;
    assign w_wr_data.mglo     = r_glo ^ r_key_lo ^ w_guid_pat;

    // Active bits and slot count; clear drops both at once
    logic [DISK_SLOTS-1:0] r_active;
    logic [CNT_W-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_active <= '0;
            r_count  <= '0;
        end else if (i_cmd.add) begin
            r_active[w_slot] <= 1'b1;
            if (r_idx >= r_count) begin
                r_count <= r_idx + CNT_W'(1);
            end
        end
    end

    // Scan pipeline: issue a read, compare it in the following cycle
    logic [CNT_W-1:0]  r_ptr;
    logic              r_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_idx;
    t_slot             r_rd_data;
    logic              w_hit, w_issue;

    assign w_hit   = r_cmp_vld && r_active[r_cmp_idx] && (r_rd_data.msig == r_sig);
    assign w_issue = i_cmd.scan && !w_hit && (r_ptr < r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_init) begin
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
        end else if (w_issue) begin
            r_ptr     <= r_ptr + CNT_W'(1);
            r_cmp_vld <= 1'b1;
            r_cmp_idx <= r_ptr[SLOT_W-1:0];
        end else if (i_cmd.scan && !w_hit) begin
            r_cmp_vld <= 1'b0;
        end
    end

    // Slot memory; inactive entries never reach the result register
    t_slot r_mem [DISK_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_mem[w_slot] <= w_wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[w_slot];
        end else if (w_issue) begin
            r_rd_data <= r_mem[r_ptr[SLOT_W-1:0]];
        end
    end

    // Result register
    logic w_out_free;
    assign w_out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            o_status         <= (i_cmd.kind == K_FAIL);
            o_found_index    <= '0;
            o_sig_out        <= '0;
            o_masked_guid_hi <= '0;
            o_masked_guid_lo <= '0;
            o_slot_count     <= r_count;
            case (i_cmd.kind)
                K_GET: begin
                    o_sig_out        <= r_rd_data.msig;
                    o_masked_guid_hi <= r_rd_data.mghi;
                    o_masked_guid_lo <= r_rd_data.mglo;
                end
                K_RES: begin
                    o_found_index <= CNT_W'(r_cmp_idx);
                    o_sig_out     <= r_rd_data.real_sig;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.req       = r_req;
    assign o_stat.armed     = r_armed;
    assign o_stat.idx_ok    = (r_idx < CNT_W'(DISK_SLOTS));
    assign o_stat.active    = r_active[w_slot];
    assign o_stat.scan_hit  = w_hit;
    assign o_stat.scan_done = !r_cmp_vld && (r_ptr >= r_count);
    assign o_stat.out_free  = w_out_free;

    `ASSERT_NEVER(a_count_in_range, i_clk, i_rst_n, r_count > CNT_W'(DISK_SLOTS), "slot count above table depth")
    `ASSERT_SYNC(a_add_covers_slot, i_clk, i_rst_n, i_cmd.add |=> (r_count > r_idx && r_active[w_slot]), "added slot not active or not counted")
    `ASSERT_SYNC(a_clear_empties, i_clk, i_rst_n, i_cmd.clr |=> (r_count == '0 && r_active == '0), "clear left table state behind")

endmodule

// ===== tb/disk_id_mask_table_test.sv =====
// Self-checking testbench for disk_id_mask_table: a directed pass, then random request beats
// with random idling on both channels, checked against a behavioral model of the slot table.
// Depends on dimt_pkg and the disk_id_mask_table RTL.
module disk_id_mask_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dimt_pkg::*;

    localparam int CYCLE_LIMIT = 800_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_REQUESTS = 178;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        t_req              req;
        logic [CNT_W-1:0]  idx;
        logic [SIG_W-1:0]  sig;
        logic [GUID_W-1:0] ghi;
        logic [GUID_W-1:0] glo;
    } t_request;

    typedef struct {
        logic              status;
        logic [CNT_W-1:0]  found;
        logic [SIG_W-1:0]  sig;
        logic [GUID_W-1:0] mghi;
        logic [GUID_W-1:0] mglo;
        logic [CNT_W-1:0]  count;
    } t_answer;

    // Stimulus side: hold every input at a known value from time zero.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_KEY_HI;
    logic [KEY_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic [1:0]           i_req_type = REQ_ADD;
    logic [CNT_W-1:0]     i_disk_index = '0;
    logic [SIG_W-1:0]     i_mbr_sig = '0;
    logic [GUID_W-1:0]    i_guid_hi = '0;
    logic [GUID_W-1:0]    i_guid_lo = '0;
    logic                 i_out_ready = 1'b0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_status;
    logic [CNT_W-1:0]     o_found_index;
    logic [SIG_W-1:0]     o_sig_out;
    logic [GUID_W-1:0]    o_masked_guid_hi;
    logic [GUID_W-1:0]    o_masked_guid_lo;
    logic [CNT_W-1:0]     o_slot_count;

    disk_id_mask_table i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_disk_index     (i_disk_index),
        .i_mbr_sig        (i_mbr_sig),
        .i_guid_hi        (i_guid_hi),
        .i_guid_lo        (i_guid_lo),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found_index    (o_found_index),
        .o_sig_out        (o_sig_out),
        .o_masked_guid_hi (o_masked_guid_hi),
        .o_masked_guid_lo (o_masked_guid_lo),
        .o_slot_count     (o_slot_count)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the block: configuration registers and slot table.
    logic [KEY_W-1:0]  key_hi_q = '0;
    logic [KEY_W-1:0]  key_lo_q = '0;
    logic              armed_q = 1'b0;
    logic              slot_live [DISK_SLOTS];
    logic [SIG_W-1:0]  slot_sig [DISK_SLOTS];
    logic [SIG_W-1:0]  slot_msig [DISK_SLOTS];
    logic [GUID_W-1:0] slot_mghi [DISK_SLOTS];
    logic [GUID_W-1:0] slot_mglo [DISK_SLOTS];
    logic [CNT_W-1:0]  slots_used = '0;

    // Masked signatures handed out by adds; resolves pick from these to get hits.
    logic [SIG_W-1:0]  known_msig [DISK_SLOTS];

    t_request requests_todo[$];
    t_answer  answers_due[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  beat_taken = 1'b0;
    bit  driving = 1'b0;
    bit  steady = 1'b0;

    initial begin
        for (int i = 0; i < DISK_SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_sig[i] = '0;
            slot_msig[i] = '0;
            slot_mghi[i] = '0;
            slot_mglo[i] = '0;
            known_msig[i] = '0;
        end
    end

    // Signature mask of slot d: the four key words folded by XOR, then the slot's golden step.
    function automatic logic [SIG_W-1:0] sig_mask(input logic [KEY_W-1:0] kh,
                                                 input logic [KEY_W-1:0] kl,
                                                 input logic [CNT_W-1:0] d);
        logic [SIG_W-1:0] step;
        step = 32'(d) * GOLDEN_STEP;
        return kh[63:32] ^ kh[31:0] ^ kl[63:32] ^ kl[31:0] ^ step;
    endfunction

    // Apply one request to the shadow table and return the result beat it must produce.
    function automatic t_answer apply_request(input t_request rq);
        t_answer          a;
        logic [GUID_W-1:0] pat;
        a = '{status: 1'b1, found: '0, sig: '0, mghi: '0, mglo: '0, count: '0};
        pat = {rq.idx, 24'h0, rq.idx, 24'h0};
        if (armed_q) begin
            case (rq.req)
                REQ_ADD: begin
                    if (rq.idx < DISK_SLOTS) begin
                        slot_sig[rq.idx]  = rq.sig;
                        slot_msig[rq.idx] = rq.sig ^ sig_mask(key_hi_q, key_lo_q, rq.idx);
                        slot_mghi[rq.idx] = rq.ghi ^ key_hi_q ^ pat;
                        slot_mglo[rq.idx] = rq.glo ^ key_lo_q ^ pat;
                        slot_live[rq.idx] = 1'b1;
                        if (rq.idx >= slots_used)
                            slots_used = rq.idx + 1'b1;
                        a.status = 1'b0;
                    end
                end
                REQ_GET: begin
                    if (rq.idx < DISK_SLOTS && slot_live[rq.idx]) begin
                        a.sig    = slot_msig[rq.idx];
                        a.mghi   = slot_mghi[rq.idx];
                        a.mglo   = slot_mglo[rq.idx];
                        a.status = 1'b0;
                    end
                end
                REQ_RESOLVE: begin
                    // Scan upward; the first live slot with a matching masked signature wins.
                    for (int i = 0; i < slots_used && i < DISK_SLOTS; i++) begin
                        if (a.status && slot_live[i] && slot_msig[i] == rq.sig) begin
                            a.found  = 8'(i);
                            a.sig    = slot_sig[i];
                            a.status = 1'b0;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < DISK_SLOTS; i++)
                        slot_live[i] = 1'b0;
                    slots_used = '0;
                    a.status = 1'b0;
                end
            endcase
        end
        a.count = slots_used;
        return a;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: MISMATCH %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Queue one request; adds to a legal slot also record the masked signature for later resolves.
    task automatic queue_request(input t_req r, input logic [CNT_W-1:0] idx,
                                 input logic [SIG_W-1:0] sig, input logic [GUID_W-1:0] ghi,
                                 input logic [GUID_W-1:0] glo);
        if (r == REQ_ADD && idx < DISK_SLOTS)
            known_msig[idx] = sig ^ sig_mask(key_hi_q, key_lo_q, idx);
        requests_todo.push_back('{req: r, idx: idx, sig: sig, ghi: ghi, glo: glo});
    endtask

    task automatic queue_random_request();
        t_req             r;
        logic [CNT_W-1:0] idx;
        logic [SIG_W-1:0] sig;
        int               pick;
        pick = $urandom_range(0, 99);
        // Mostly legal slots; now and then any index, to reach the bad-index path and upper bits.
        idx = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, DISK_SLOTS - 1))
                                            : 8'($urandom);
        sig = $urandom;
        if (pick < 38)
            r = REQ_ADD;
        else if (pick < 62)
            r = REQ_GET;
        else if (pick < 96) begin
            r = REQ_RESOLVE;
            if ($urandom_range(0, 99) < 70)
                sig = known_msig[$urandom_range(0, DISK_SLOTS - 1)];
        end else
            r = REQ_CLEAR;
        queue_request(r, idx, sig, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // Write one register at a falling edge; the shadow follows at once since the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [KEY_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_KEY_HI: key_hi_q = val;
            CFG_KEY_LO: key_lo_q = val;
            default:    armed_q  = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait for every queued beat to go in and every result to come back, then let the block settle.
    task automatic drain();
        while (requests_todo.size() != 0 || i_in_valid || answers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: advance to the next beat only once the current one is taken.
    always @(negedge i_clk) begin
        t_request nxt;
        if (driving && (!i_in_valid || beat_taken)) begin
            beat_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (requests_todo.size() != 0) begin
                nxt = requests_todo.pop_front();
                i_req_type   <= nxt.req;
                i_disk_index <= nxt.idx;
                i_mbr_sig    <= nxt.sig;
                i_guid_hi    <= nxt.ghi;
                i_guid_lo    <= nxt.glo;
                i_in_valid   <= 1'b1;
                send_gap = steady ? 0 : idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: drop ready for random stretches, never in steady phases.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25)
                stall_left = idle_len();
        end
    end

    // Monitor: predict on every accepted request beat, check every accepted result beat.
    always @(posedge i_clk) begin
        t_request seen;
        t_answer  want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                seen = '{req: t_req'(i_req_type), idx: i_disk_index, sig: i_mbr_sig,
                         ghi: i_guid_hi, glo: i_guid_lo};
                answers_due.push_back(apply_request(seen));
                beat_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 64'(o_status), '0);
                end else begin
                    want = answers_due.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_found_index !== want.found)
                        report_mismatch("found_index", 64'(o_found_index), 64'(want.found));
                    if (o_sig_out !== want.sig)
                        report_mismatch("sig_out", 64'(o_sig_out), 64'(want.sig));
                    if (o_masked_guid_hi !== want.mghi)
                        report_mismatch("masked_guid_hi", o_masked_guid_hi, want.mghi);
                    if (o_masked_guid_lo !== want.mglo)
                        report_mismatch("masked_guid_lo", o_masked_guid_lo, want.mglo);
                    if (o_slot_count !== want.count)
                        report_mismatch("slot_count", 64'(o_slot_count), 64'(want.count));
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [SIG_W-1:0] shared;
        logic [KEY_W-1:0] kh;
        logic [KEY_W-1:0] kl;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        driving = 1'b1;

        // Disarmed after reset: every kind of request fails, clear included.
        queue_request(REQ_ADD, 8'd0, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_GET, 8'd0, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_RESOLVE, 8'd0, 32'h0, {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_CLEAR, 8'($urandom), $urandom, {$urandom, $urandom},
                      {$urandom, $urandom});
        queue_request(REQ_ADD, 8'hFF, 32'hFFFF_FFFF, '1, '1);
        drain();

        write_reg(CFG_KEY_HI, '1);
        write_reg(CFG_KEY_LO, '0);
        write_reg(CFG_ARMED, 64'd1);

        // Field extremes on the lowest and highest slots, then both sides of the index limit.
        queue_request(REQ_ADD, 8'd0, 32'hFFFF_FFFF, '1, '1);
        queue_request(REQ_ADD, 8'(DISK_SLOTS - 1), 32'h0, '0, '0);
        queue_request(REQ_ADD, 8'(DISK_SLOTS), $urandom, {$urandom, $urandom},
                      {$urandom, $urandom});
        queue_request(REQ_ADD, 8'hFF, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_GET, 8'd0, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_GET, 8'(DISK_SLOTS - 1), $urandom, '1, '1);
        queue_request(REQ_GET, 8'd7, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_GET, 8'(DISK_SLOTS), $urandom, '0, '0);
        queue_request(REQ_RESOLVE, 8'($urandom), known_msig[DISK_SLOTS - 1], '0, '0);
        queue_request(REQ_RESOLVE, 8'($urandom), $urandom, '1, '1);

        // Two slots share one masked signature: resolve must pick the lower one first.
        shared = $urandom;
        queue_request(REQ_ADD, 8'd2, shared ^ sig_mask(key_hi_q, key_lo_q, 8'd2),
                      {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_ADD, 8'd9, shared ^ sig_mask(key_hi_q, key_lo_q, 8'd9),
                      {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_RESOLVE, 8'($urandom), shared, '0, '0);
        queue_request(REQ_ADD, 8'd2, ~(shared ^ sig_mask(key_hi_q, key_lo_q, 8'd2)),
                      {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_RESOLVE, 8'($urandom), shared, '0, '0);

        // Clear empties the table: gets and resolves miss until slots are added again.
        queue_request(REQ_CLEAR, 8'($urandom), $urandom, {$urandom, $urandom},
                      {$urandom, $urandom});
        queue_request(REQ_GET, 8'd0, $urandom, '0, '0);
        queue_request(REQ_RESOLVE, 8'($urandom), shared, '0, '0);
        queue_request(REQ_ADD, 8'd5, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        queue_request(REQ_GET, 8'd5, $urandom, '0, '0);
        queue_request(REQ_GET, 8'hFF, $urandom, '0, '0);
        drain();

        // Random phases: new key each time (extremes first), one disarmed phase, two steady ones.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            kh = {$urandom, $urandom};
            kl = {$urandom, $urandom};
            if (p == 0) begin
                kh = '0;
                kl = '1;
            end else if (p == 1) begin
                kh = '1;
                kl = '0;
            end
            write_reg(CFG_KEY_HI, kh);
            write_reg(CFG_KEY_LO, kl);
            write_reg(CFG_ARMED, (p == 3) ? 64'd0 : 64'd1);
            steady = (p == 2 || p == 5);
            for (int n = 0; n < PHASE_REQUESTS; n++)
                queue_random_request();
            drain();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
